FILE: rtl/core/olad_pkg.sv
`default_nettype none

package olad_pkg;

	// list geometry
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         count_t;

	// command codes
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE,
		S_DUMP
	} state_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic append;   // write append data at wr_idx
		logic shift;    // every cell takes its upper neighbor
		logic recirc;   // tail cell takes the head value during a shift
		idx_t wr_idx;
		idx_t tail_idx;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/olad_cell.sv
`default_nettype none

module olad_cell (
	input  wire                clk,
	input  olad_pkg::cell_ctl_t ctl,
	input  olad_pkg::idx_t     cell_idx,
	input  olad_pkg::data_t    append_data,
	input  olad_pkg::data_t    next_data,
	input  olad_pkg::data_t    head_data,
	output olad_pkg::data_t    data
);
	import olad_pkg::*;

	data_t data_q;

	// one list slot: load on append, move toward the head on shift
	always_ff @(posedge clk) begin
		if (ctl.append && (cell_idx == ctl.wr_idx)) begin
			data_q <= append_data;
		end else if (ctl.shift) begin
			if (ctl.recirc && (cell_idx == ctl.tail_idx)) begin
				data_q <= head_data;
			end else begin
				data_q <= next_data;
			end
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/olad_ctrl.sv
`default_nettype none

module olad_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  [1:0]          command,
	input  olad_pkg::data_t     value,
	input  olad_pkg::data_t     head,
	output olad_pkg::cell_ctl_t ctl,
	output logic                busy,
	output logic                strobe,
	output logic [1:0]          status,
	output olad_pkg::data_t     entry_value,
	output olad_pkg::count_t    entry_count,
	output logic                last
);
	import olad_pkg::*;

	state_t state_q, state_d;
	count_t count_q, count_d;
	count_t n_q;
	idx_t   step_q;
	logic   found_q;
	data_t  value_q;

	logic   strobe_q, strobe_d;
	logic [1:0] status_q, status_d;
	data_t  evalue_q, evalue_d;
	count_t ecount_q, ecount_d;
	logic   last_q, last_d;

	logic   accept;
	logic   last_step;
	logic   match;
	count_t count_m1;

	assign accept    = start && (state_q == S_IDLE);
	assign last_step = (CNT_W'(step_q) == (n_q - CNT_W'(1)));
	assign match     = !found_q && (head == value_q);
	assign count_m1  = count_q - CNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (count_q != '0)) begin
					if (command == CMD_REMOVE) state_d = S_REMOVE;
					if (command == CMD_DUMP)   state_d = S_DUMP;
				end
			end
			S_REMOVE, S_DUMP: begin
				if (last_step) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// cell control, fill count and result
	always_comb begin
		ctl          = '0;
		ctl.wr_idx   = count_q[IDX_W-1:0];
		ctl.tail_idx = count_m1[IDX_W-1:0];
		count_d      = count_q;
		strobe_d     = 1'b0;
		status_d     = ST_OK;
		evalue_d     = '0;
		last_d       = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_APPEND: begin
							strobe_d = 1'b1;
							if (count_q == CNT_W'(DEPTH)) begin
								status_d = ST_FULL;
							end else begin
								ctl.append = 1'b1;
								count_d    = count_q + CNT_W'(1);
							end
						end
						CMD_REMOVE, CMD_DUMP: begin
							if (count_q == '0) begin
								strobe_d = 1'b1;
								status_d = ST_EMPTY;
							end
						end
						default: ;
					endcase
				end
			end
			S_REMOVE: begin
				// rotate once per original entry, dropping the first match
				ctl.shift  = 1'b1;
				ctl.recirc = !match;
				if (match) count_d = count_m1;
				if (last_step) begin
					strobe_d = 1'b1;
					status_d = (found_q || match) ? ST_OK : ST_NOT_FOUND;
				end
			end
			S_DUMP: begin
				// full rotation, head is shown each cycle
				ctl.shift  = 1'b1;
				ctl.recirc = 1'b1;
				strobe_d   = 1'b1;
				evalue_d   = head;
				last_d     = last_step;
			end
			default: ;
		endcase
		ecount_d = count_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
			found_q  <= 1'b0;
			step_q   <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
			if (accept) begin
				found_q <= 1'b0;
				step_q  <= '0;
			end else if (state_q != S_IDLE) begin
				if (match && (state_q == S_REMOVE)) found_q <= 1'b1;
				step_q <= step_q + IDX_W'(1);
			end
		end
	end

	// transaction payload and search operands
	always_ff @(posedge clk) begin
		status_q <= status_d;
		evalue_q <= evalue_d;
		ecount_q <= ecount_d;
		last_q   <= last_d;
		if (accept) begin
			n_q     <= count_q;
			value_q <= value;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign strobe      = strobe_q;
	assign status      = status_q;
	assign entry_value = evalue_q;
	assign entry_count = ecount_q;
	assign last        = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/ordered_list_append_delete_unit.sv
// Append, and remove or dump on an empty list: one transaction, result in the cycle after start.
// Remove: one rotation step of the cell row per entry, then the result.
// Dump: N results back to back, one per entry, head first.
// A new command is taken in the cycle the final result shows; results cannot be stalled.
// Reset (arst_n low, asynchronous) empties the list; entry storage itself is not cleared.
`default_nettype none

module ordered_list_append_delete_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire  [1:0]        command,
	input  olad_pkg::data_t   value,
	output logic              strobe,
	output logic [1:0]        status,
	output olad_pkg::data_t   entry_value,
	output olad_pkg::count_t  entry_count,
	output logic              last
);
	import olad_pkg::*;

	cell_ctl_t ctl;
	data_t     cell_data [DEPTH];

	olad_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.value       (value),
		.head        (cell_data[0]),
		.ctl         (ctl),
		.busy        (busy),
		.strobe      (strobe),
		.status      (status),
		.entry_value (entry_value),
		.entry_count (entry_count),
		.last        (last)
	);

	// row of slots, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		data_t nxt;
		if (i < DEPTH - 1) begin : g_mid
			assign nxt = cell_data[i+1];
		end else begin : g_end
			assign nxt = cell_data[0];
		end
		olad_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.cell_idx    (IDX_W'(i)),
			.append_data (value),
			.next_data   (nxt),
			.head_data   (cell_data[0]),
			.data        (cell_data[i])
		);
	end

endmodule

`default_nettype wire

FILE: rtl/core/olad_checker.sv
`default_nettype none

module olad_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                start,
	input wire                busy,
	input wire [1:0]          command,
	input wire                strobe,
	input wire [1:0]          status,
	input olad_pkg::data_t    entry_value,
	input olad_pkg::count_t   entry_count,
	input wire                last
);
	import olad_pkg::*;

	// fill level never exceeds capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (entry_count <= CNT_W'(DEPTH)))
		else $error("entry_count above capacity");

	// full status only on a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_FULL)) |-> (entry_count == CNT_W'(DEPTH)))
		else $error("full status with room left");

	// empty status is a single closing transaction with no data
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_EMPTY)) |->
		(last && (entry_count == '0) && (entry_value == '0)))
		else $error("malformed empty result");

	// append answers in the next cycle
	a_append_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_APPEND)) |=> (strobe && last))
		else $error("append result missing");

	// dump results come back to back until last
	a_dump_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside dump");

endmodule

bind ordered_list_append_delete_unit olad_checker u_olad_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.command     (command),
	.strobe      (strobe),
	.status      (status),
	.entry_value (entry_value),
	.entry_count (entry_count),
	.last        (last)
);

`default_nettype wire
